/* hdl/h264_rtp_depacketizer_macros.svh */
// assertion macros for the h264 rtp depacketizer
// used by the core and the emitter; empty bodies under synthesis
`ifndef H264_RTP_DEPACKETIZER_MACROS_SVH
`define H264_RTP_DEPACKETIZER_MACROS_SVH
`ifndef SYNTHESIS
`define H264RTP_ASSERT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define H264RTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define H264RTP_ASSERT(lbl, clk, rst, ante, cons, msg)
`define H264RTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/h264rtp_pkg.sv */
// shared types and constants for the h264 rtp depacketizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package h264rtp_pkg;

  localparam int CFG_DATA_W = 7;

  localparam logic [0:0] REG_EMIT_START_CODE   = 1'd0;
  localparam logic [0:0] REG_H264_PAYLOAD_TYPE = 1'd1;

  localparam logic       EMIT_START_CODE_RESET   = 1'b1;
  localparam logic [6:0] H264_PAYLOAD_TYPE_RESET = 7'd96;

  localparam logic [4:0] FUA_TYPE = 5'd28;
  localparam logic [4:0] TYPE_SPS = 5'd7;
  localparam logic [4:0] TYPE_PPS = 5'd8;

  localparam logic [2:0] SC_LONG     = 3'd4;
  localparam logic [2:0] SC_SHORT    = 3'd3;
  localparam logic [2:0] SC_NONE     = 3'd0;
  localparam logic [2:0] MAX_RESULTS = 3'd6;

  localparam logic [7:0] SC_LAST_BYTE = 8'h01;
  localparam logic [7:0] SC_ZERO_BYTE = 8'h00;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] rtp_seq;
    logic [31:0] timestamp;
    logic [6:0]  payload_type;
    logic        header_ok;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        nal_first;
    logic        nal_last;
    logic        nal_abort;
    logic [31:0] nal_timestamp;
  } out_beat_t;

  // results of one input beat: optional abort, start code, up to two data bytes
  typedef struct packed {
    logic        ab;
    logic [31:0] ab_ts;
    logic [2:0]  sc_len;
    logic [1:0]  dcnt;
    logic [7:0]  d0;
    logic        d0_first;
    logic [7:0]  d1;
    logic        d_last;
    logic [31:0] d_ts;
  } desc_t;

endpackage
`default_nettype wire

/* hdl/h264_rtp_depacketizer.sv */
// H.264 RTP depacketizer: one RTP payload byte per input beat in, NAL bytes out.
// Each payload beat is registered, decoded combinationally against the depacketizer
// state and turned into a descriptor of up to six output beats (abort marker,
// start code, header and data bytes) held in the result register. An input beat
// that yields one output beat, or none, is taken every cycle while nal_ready is
// high; a beat that yields more holds the result register until its last output
// beat is accepted, and each start code byte and abort marker is a beat of its own.
// Configuration writes are always ready and take effect at once.
// depends on h264rtp_pkg, h264rtp_in_reg, h264rtp_core and h264rtp_emit
`timescale 1ns / 1ps
`default_nettype none
module h264_rtp_depacketizer (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               pkt_valid,
  output logic                              pkt_ready,
  input  h264rtp_pkg::in_beat_t             pkt,
  output logic                              nal_valid,
  input  wire                               nal_ready,
  output h264rtp_pkg::out_beat_t            nal,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [0:0]                         cfg_index,
  input  wire [h264rtp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import h264rtp_pkg::*;

  logic     held;
  logic     free;
  logic     take;
  in_beat_t beat;
  desc_t    desc;

  assign cfg_ready = 1'b1;
  assign take      = held && free;

  h264rtp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .take      (take),
    .held      (held),
    .beat      (beat)
  );

  h264rtp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .beat      (beat),
    .desc      (desc)
  );

  h264rtp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .desc_in   (desc),
    .free      (free),
    .nal_valid (nal_valid),
    .nal_ready (nal_ready),
    .nal       (nal)
  );

endmodule
`default_nettype wire

/* hdl/h264rtp_in_reg.sv */
// input register for payload beats
// depends on h264rtp_pkg
`timescale 1ns / 1ps
`default_nettype none
module h264rtp_in_reg (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   pkt_valid,
  output logic                  pkt_ready,
  input  h264rtp_pkg::in_beat_t pkt,
  input  wire                   take,
  output logic                  held,
  output h264rtp_pkg::in_beat_t beat
);
  import h264rtp_pkg::*;

  assign pkt_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (pkt_valid && pkt_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && pkt_ready) begin
      beat <= pkt;
    end
  end

endmodule
`default_nettype wire

/* hdl/h264rtp_core.sv */
// depacketizer state and per-beat decode into a result descriptor
// depends on h264rtp_pkg and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "h264_rtp_depacketizer_macros.svh"
module h264rtp_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  input  wire [0:0]                    cfg_index,
  input  wire [h264rtp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                          take,
  input  h264rtp_pkg::in_beat_t        beat,
  output h264rtp_pkg::desc_t           desc
);
  import h264rtp_pkg::*;

  typedef enum logic [1:0] {
    MODE_IGNORE = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_FUA    = 2'd2,
    MODE_DROP   = 2'd3
  } mode_t;

  logic        emit_start_code;
  logic [6:0]  h264_payload_type;

  logic        fragment_open, fragment_open_next;
  logic [15:0] prev_seq, prev_seq_next;
  logic [31:0] prev_ts, prev_ts_next;
  mode_t       packet_mode, packet_mode_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [1:0]  saved_nri, saved_nri_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  logic        pending_end, pending_end_next;

  logic        seq_bad, cont_ok, cont_abort;
  logic        hs, he, hr;
  logic [4:0]  nal_type;

  assign nal_type = beat.payload_byte[4:0];
  assign hs = held_byte[7];
  assign he = held_byte[6];
  assign hr = held_byte[5];

  assign seq_bad = (beat.timestamp != prev_ts) || (beat.rtp_seq < prev_seq) ||
                   ({1'b0, beat.rtp_seq} > ({1'b0, prev_seq} + 17'd1));
  assign cont_abort = fragment_open && seq_bad;
  assign cont_ok    = fragment_open && !seq_bad && (beat.rtp_seq != prev_seq);

  always_comb begin
    logic emit_data;
    logic pe_eff;
    emit_data          = 1'b0;
    pe_eff             = pending_end;
    fragment_open_next = fragment_open;
    prev_seq_next      = prev_seq;
    prev_ts_next       = prev_ts;
    packet_mode_next   = packet_mode;
    byte_position_next = byte_position;
    saved_nri_next     = saved_nri;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    pending_end_next   = pending_end;
    desc          = '0;
    desc.ab_ts    = prev_ts;
    desc.d_ts     = prev_ts;
    desc.sc_len   = SC_NONE;

    if (beat.first_byte) begin
      if (packet_mode == MODE_SINGLE) begin
        desc.ab = 1'b1;
      end
      packet_mode_next   = MODE_IGNORE;
      held_valid_next    = 1'b0;
      pending_end_next   = 1'b0;
      byte_position_next = 2'd0;
      if (beat.header_ok && (beat.payload_type == h264_payload_type)) begin
        byte_position_next = 2'd1;
        if (nal_type != FUA_TYPE) begin
          if (fragment_open) begin
            desc.ab            = 1'b1;
            fragment_open_next = 1'b0;
          end
          prev_seq_next = beat.rtp_seq;
          prev_ts_next  = beat.timestamp;
          if (emit_start_code) begin
            desc.sc_len = (nal_type == TYPE_SPS || nal_type == TYPE_PPS) ? SC_LONG : SC_SHORT;
          end
          desc.dcnt     = 2'd1;
          desc.d0       = beat.payload_byte;
          desc.d0_first = !emit_start_code;
          desc.d_last   = beat.last_byte;
          desc.d_ts     = beat.timestamp;
          packet_mode_next = beat.last_byte ? MODE_IGNORE : MODE_SINGLE;
        end else begin
          saved_nri_next   = beat.payload_byte[6:5];
          packet_mode_next = MODE_FUA;
          if (beat.last_byte) begin
            if (cont_abort) begin
              desc.ab            = 1'b1;
              fragment_open_next = 1'b0;
            end
            if (cont_ok) begin
              prev_seq_next = beat.rtp_seq;
            end
            packet_mode_next = MODE_IGNORE;
          end
        end
      end
    end else begin
      case (packet_mode)
        MODE_IGNORE: begin
        end
        MODE_SINGLE: begin
          desc.dcnt   = 2'd1;
          desc.d0     = beat.payload_byte;
          desc.d_last = beat.last_byte;
          if (beat.last_byte) begin
            packet_mode_next = MODE_IGNORE;
          end
        end
        MODE_DROP: begin
          if (beat.last_byte) begin
            packet_mode_next = MODE_IGNORE;
          end
        end
        MODE_FUA: begin
          if (byte_position == 2'd1) begin
            held_byte_next     = beat.payload_byte;
            held_valid_next    = 1'b1;
            byte_position_next = 2'd2;
            if (beat.last_byte) begin
              if (cont_abort) begin
                desc.ab            = 1'b1;
                fragment_open_next = 1'b0;
              end
              if (cont_ok) begin
                prev_seq_next = beat.rtp_seq;
              end
              held_valid_next  = 1'b0;
              packet_mode_next = MODE_IGNORE;
            end
          end else begin
            emit_data = 1'b1;
            if (held_valid) begin
              held_valid_next = 1'b0;
              if (hs && !hr && !he) begin
                emit_data          = 1'b0;
                desc.ab            = fragment_open;
                fragment_open_next = 1'b1;
                prev_ts_next       = beat.timestamp;
                prev_seq_next      = beat.rtp_seq;
                pending_end_next   = 1'b0;
                desc.sc_len        = emit_start_code ? SC_SHORT : SC_NONE;
                desc.dcnt          = 2'd2;
                desc.d0            = {1'b0, saved_nri, held_byte[4:0]};
                desc.d0_first      = !emit_start_code;
                desc.d1            = beat.payload_byte;
                desc.d_ts          = beat.timestamp;
                if (beat.last_byte) begin
                  packet_mode_next = MODE_IGNORE;
                end
              end else if (!cont_ok) begin
                emit_data = 1'b0;
                if (cont_abort) begin
                  desc.ab            = 1'b1;
                  fragment_open_next = 1'b0;
                end
                packet_mode_next = beat.last_byte ? MODE_IGNORE : MODE_DROP;
              end else begin
                prev_seq_next    = beat.rtp_seq;
                pe_eff           = !hs && !hr && he;
                pending_end_next = pe_eff;
              end
            end
            if (emit_data) begin
              desc.dcnt   = 2'd1;
              desc.d0     = beat.payload_byte;
              desc.d_last = beat.last_byte && pe_eff;
              if (beat.last_byte) begin
                if (pe_eff) begin
                  fragment_open_next = 1'b0;
                end
                pending_end_next = 1'b0;
                packet_mode_next = MODE_IGNORE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_start_code   <= EMIT_START_CODE_RESET;
      h264_payload_type <= H264_PAYLOAD_TYPE_RESET;
      fragment_open     <= 1'b0;
      prev_seq          <= '0;
      prev_ts           <= '0;
      packet_mode       <= MODE_IGNORE;
      byte_position     <= '0;
      saved_nri         <= '0;
      held_byte         <= '0;
      held_valid        <= 1'b0;
      pending_end       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_EMIT_START_CODE:   emit_start_code   <= cfg_data[0];
          REG_H264_PAYLOAD_TYPE: h264_payload_type <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      if (take) begin
        fragment_open <= fragment_open_next;
        prev_seq      <= prev_seq_next;
        prev_ts       <= prev_ts_next;
        packet_mode   <= packet_mode_next;
        byte_position <= byte_position_next;
        saved_nri     <= saved_nri_next;
        held_byte     <= held_byte_next;
        held_valid    <= held_valid_next;
        pending_end   <= pending_end_next;
      end
    end
  end

  // a single nal in flight never overlaps an open fragment
  `H264RTP_ASSERT(a_single_no_frag, clk, rst, packet_mode == MODE_SINGLE, !fragment_open, "single nal with open fragment")
  // the fu header is only held inside a fu-a packet
  `H264RTP_ASSERT(a_held_in_fua, clk, rst, held_valid, packet_mode == MODE_FUA, "fu header held outside fu-a packet")

endmodule
`default_nettype wire

/* hdl/h264rtp_emit.sv */
// result register: holds one beat's descriptor and serialises its output beats
// depends on h264rtp_pkg and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "h264_rtp_depacketizer_macros.svh"
module h264rtp_emit (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    load,
  input  h264rtp_pkg::desc_t     desc_in,
  output logic                   free,
  output logic                   nal_valid,
  input  wire                    nal_ready,
  output h264rtp_pkg::out_beat_t nal
);
  import h264rtp_pkg::*;

  desc_t      d;
  logic [2:0] total;
  logic [2:0] idx;
  logic [2:0] total_in;
  logic       at_last;
  logic [2:0] k;
  logic [2:0] j;
  logic       in_ab;
  logic       in_sc;

  assign total_in  = {2'b00, desc_in.ab} + desc_in.sc_len + {1'b0, desc_in.dcnt};
  assign nal_valid = (total != 3'd0);
  assign at_last   = (idx == total - 3'd1);
  assign free      = !nal_valid || (nal_ready && at_last);

  assign k     = idx - {2'b00, d.ab};
  assign j     = k - d.sc_len;
  assign in_ab = d.ab && (idx == 3'd0);
  assign in_sc = !in_ab && (k < d.sc_len);

  always_comb begin
    nal = '0;
    if (in_ab) begin
      nal.nal_abort     = 1'b1;
      nal.nal_timestamp = d.ab_ts;
    end else if (in_sc) begin
      nal.out_byte      = (k == d.sc_len - 3'd1) ? SC_LAST_BYTE : SC_ZERO_BYTE;
      nal.nal_first     = (k == 3'd0);
      nal.nal_timestamp = d.d_ts;
    end else begin
      nal.out_byte      = j[0] ? d.d1 : d.d0;
      nal.nal_first     = !j[0] && d.d0_first;
      nal.nal_last      = d.d_last && (j[1:0] == d.dcnt - 2'd1);
      nal.nal_timestamp = d.d_ts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      idx   <= '0;
    end else if (load) begin
      total <= total_in;
      idx   <= '0;
    end else if (nal_valid && nal_ready) begin
      if (at_last) begin
        total <= '0;
        idx   <= '0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d <= desc_in;
    end
  end

  `H264RTP_ASSERT(a_total_max, clk, rst, 1'b1, total <= MAX_RESULTS, "too many results for one beat")
  `H264RTP_ASSERT(a_idx_range, clk, rst, nal_valid, idx < total, "result index past end")
  `H264RTP_ASSERT_NEXT(a_stall_hold, clk, rst, nal_valid && !nal_ready, nal_valid && $stable(idx), "stalled result moved")

endmodule
`default_nettype wire

/* tb/tb_h264_rtp_depacketizer.sv */
// self-checking testbench for h264_rtp_depacketizer: directed and random rtp payload beats,
// nal beats predicted in-bench and compared field by field, bursty source and stalling sink
// depends on h264rtp_pkg and the h264_rtp_depacketizer rtl
`timescale 1ns / 1ps
module tb_h264_rtp_depacketizer;
  import h264rtp_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 50;
  localparam logic [1:0] POS_NONE = 2'd0;
  localparam logic [1:0] POS_HDR = 2'd1;
  localparam logic [1:0] POS_DATA = 2'd2;

  typedef enum logic [1:0] {PM_IGNORE, PM_SINGLE, PM_FUA, PM_DROP} pkt_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic pkt_valid = 1'b0;
  logic pkt_ready;
  in_beat_t pkt = '0;
  logic nal_valid;
  logic nal_ready = 1'b0;
  out_beat_t nal;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  h264_rtp_depacketizer i_dut (
    .clk(clk), .rst(rst),
    .pkt_valid(pkt_valid), .pkt_ready(pkt_ready), .pkt(pkt),
    .nal_valid(nal_valid), .nal_ready(nal_ready), .nal(nal),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  in_beat_t pkt_pending_q[$];
  out_beat_t nal_expected_q[$];
  logic [7:0] payload_q[$];

  // mirror of the depacketizer
  logic emit_sc_m = EMIT_START_CODE_RESET;
  logic [6:0] h264_pt_m = H264_PAYLOAD_TYPE_RESET;
  logic frag_open_m;
  logic [15:0] last_seq_m;
  logic [31:0] last_ts_m;
  pkt_mode_t pkt_mode_m;
  logic [1:0] byte_pos_m;
  logic [1:0] nri_m;
  logic [7:0] fu_hdr_m;
  logic fu_hdr_held_m;
  logic end_frag_m;

  logic pkt_fire = 1'b0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int useful_count = 0;
  bit noise_mode = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_cycle = 0;
  logic [15:0] cur_seq = 16'd0;
  logic [31:0] cur_ts = 32'd0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic push_beat(input logic [7:0] b, input logic f, input logic l, input logic a,
                           input logic [31:0] ts);
    out_beat_t o;
    o.out_byte = b;
    o.nal_first = f;
    o.nal_last = l;
    o.nal_abort = a;
    o.nal_timestamp = ts;
    nal_expected_q.insert(nal_expected_q.size(), o);
  endtask

  task automatic push_abort();
    push_beat(8'h00, 1'b0, 1'b0, 1'b1, last_ts_m);
  endtask

  task automatic push_start_code(input int len, input logic [31:0] ts, output logic nal_begins);
    int i;
    nal_begins = 1'b1;
    if (emit_sc_m) begin
      for (i = 0; i < len; i++)
        push_beat((i == len - 1) ? SC_LAST_BYTE : SC_ZERO_BYTE, i == 0, 1'b0, 1'b0, ts);
      nal_begins = 1'b0;
    end
  endtask

  // middle or end fragment against the open nal
  task automatic check_continuation(input logic [15:0] seq, input logic [31:0] ts,
                                    output logic goes_on);
    goes_on = 1'b0;
    if (frag_open_m) begin
      if (ts != last_ts_m || seq < last_seq_m || {1'b0, seq} > {1'b0, last_seq_m} + 17'd1) begin
        push_abort();
        frag_open_m = 1'b0;
      end else if (seq != last_seq_m) begin
        last_seq_m = seq;
        goes_on = 1'b1;
      end
    end
  endtask

  task automatic predict_nal(input in_beat_t p);
    logic [4:0] t;
    logic f, goes_on, s, e, r;
    if (p.first_byte) begin
      if (pkt_mode_m == PM_SINGLE) push_abort();
      pkt_mode_m = PM_IGNORE;
      fu_hdr_held_m = 1'b0;
      end_frag_m = 1'b0;
      byte_pos_m = POS_NONE;
      if (!p.header_ok || p.payload_type != h264_pt_m) return;
      byte_pos_m = POS_HDR;
      t = p.payload_byte[4:0];
      if (t != FUA_TYPE) begin
        if (frag_open_m) begin
          push_abort();
          frag_open_m = 1'b0;
        end
        last_seq_m = p.rtp_seq;
        last_ts_m = p.timestamp;
        push_start_code((t == TYPE_SPS || t == TYPE_PPS) ? SC_LONG : SC_SHORT, p.timestamp, f);
        push_beat(p.payload_byte, f, p.last_byte, 1'b0, p.timestamp);
        pkt_mode_m = p.last_byte ? PM_IGNORE : PM_SINGLE;
        return;
      end
      nri_m = p.payload_byte[6:5];
      pkt_mode_m = PM_FUA;
      if (p.last_byte) begin
        check_continuation(p.rtp_seq, p.timestamp, goes_on);
        pkt_mode_m = PM_IGNORE;
      end
      return;
    end
    if (pkt_mode_m == PM_IGNORE) return;
    if (pkt_mode_m == PM_SINGLE) begin
      push_beat(p.payload_byte, 1'b0, p.last_byte, 1'b0, last_ts_m);
      if (p.last_byte) pkt_mode_m = PM_IGNORE;
      return;
    end
    if (pkt_mode_m == PM_DROP) begin
      if (p.last_byte) pkt_mode_m = PM_IGNORE;
      return;
    end
    if (byte_pos_m == POS_HDR) begin
      fu_hdr_m = p.payload_byte;
      fu_hdr_held_m = 1'b1;
      byte_pos_m = POS_DATA;
      if (p.last_byte) begin
        check_continuation(p.rtp_seq, p.timestamp, goes_on);
        fu_hdr_held_m = 1'b0;
        pkt_mode_m = PM_IGNORE;
      end
      return;
    end
    if (fu_hdr_held_m) begin
      s = fu_hdr_m[7];
      e = fu_hdr_m[6];
      r = fu_hdr_m[5];
      fu_hdr_held_m = 1'b0;
      if (s && !r && !e) begin
        if (frag_open_m) push_abort();
        frag_open_m = 1'b1;
        last_ts_m = p.timestamp;
        last_seq_m = p.rtp_seq;
        end_frag_m = 1'b0;
        push_start_code(SC_SHORT, p.timestamp, f);
        push_beat({1'b0, nri_m, fu_hdr_m[4:0]}, f, 1'b0, 1'b0, p.timestamp);
        push_beat(p.payload_byte, 1'b0, 1'b0, 1'b0, p.timestamp);
        if (p.last_byte) pkt_mode_m = PM_IGNORE;
        return;
      end
      check_continuation(p.rtp_seq, p.timestamp, goes_on);
      if (!goes_on) begin
        pkt_mode_m = p.last_byte ? PM_IGNORE : PM_DROP;
        return;
      end
      end_frag_m = !s && !r && e;
    end
    push_beat(p.payload_byte, 1'b0, p.last_byte && end_frag_m, 1'b0, last_ts_m);
    if (p.last_byte) begin
      if (end_frag_m) frag_open_m = 1'b0;
      end_frag_m = 1'b0;
      pkt_mode_m = PM_IGNORE;
    end
  endtask

  task automatic check_nal_beat(input out_beat_t got);
    out_beat_t want;
    if (nal_expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, byte %02h", got.out_byte));
      return;
    end
    want = nal_expected_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.nal_first !== want.nal_first)
      report_mismatch($sformatf("nal_first %b, want %b", got.nal_first, want.nal_first));
    if (got.nal_last !== want.nal_last)
      report_mismatch($sformatf("nal_last %b, want %b", got.nal_last, want.nal_last));
    if (got.nal_abort !== want.nal_abort)
      report_mismatch($sformatf("nal_abort %b, want %b", got.nal_abort, want.nal_abort));
    if (got.nal_timestamp !== want.nal_timestamp)
      report_mismatch($sformatf("nal_timestamp %08h, want %08h",
                                got.nal_timestamp, want.nal_timestamp));
  endtask

  // monitor: predicts on accepted payload beats, checks accepted nal beats
  always @(posedge clk) begin
    if (rst) begin
      pkt_fire = 1'b0;
      idle_cycles = 0;
      frag_open_m = 1'b0;
      last_seq_m = '0;
      last_ts_m = '0;
      pkt_mode_m = PM_IGNORE;
      byte_pos_m = POS_NONE;
      nri_m = '0;
      fu_hdr_m = '0;
      fu_hdr_held_m = 1'b0;
      end_frag_m = 1'b0;
    end else begin
      pkt_fire = pkt_valid && pkt_ready;
      if (pkt_fire) predict_nal(pkt);
      if (nal_valid && nal_ready) check_nal_beat(nal);
      if (pkt_fire || (nal_valid && nal_ready) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // source: bursts of random length, random gaps in between
  always @(negedge clk) begin : source_side
    logic next_valid;
    next_valid = pkt_valid && !pkt_fire;
    if (!rst && (!pkt_valid || pkt_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pkt_pending_q.size() != 0) begin
        pkt <= pkt_pending_q.pop_front();
        next_valid = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
    pkt_valid <= next_valid;
  end

  // sink: cycles through free-running, random, sparse and long-stall patterns
  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 97) % 4)
      0: nal_ready <= 1'b1;
      1: nal_ready <= 1'($urandom);
      2: nal_ready <= (rx_cycle % 5 == 0);
      default: nal_ready <= ((rx_cycle / 13) % 2 == 0);
    endcase
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_h264_rtp_depacketizer: done, errors");
    $finish;
  end

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_EMIT_START_CODE) emit_sc_m = val[0];
    else h264_pt_m = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(input logic [7:0] b, input logic fb, input logic lb,
                          input logic [15:0] seq, input logic [31:0] ts,
                          input logic [6:0] pt, input logic ok);
    in_beat_t p;
    p.payload_byte = b;
    p.first_byte = fb;
    p.last_byte = lb;
    p.rtp_seq = seq;
    p.timestamp = ts;
    p.payload_type = pt;
    p.header_ok = ok;
    pkt_pending_q.insert(pkt_pending_q.size(), p);
    if (!noise_mode) useful_count++;
  endtask

  // sends payload_q as one packet, or twice if twice is set; payload type and header_ok only matter on the first beat
  task automatic add_packet(input logic [15:0] seq, input logic [31:0] ts, input logic [6:0] pt,
                            input logic ok, input logic close, input bit twice);
    int i, rep;
    for (rep = 0; rep < (twice ? 2 : 1); rep++)
      for (i = 0; i < payload_q.size(); i++) begin
        if (i == 0)
          add_item(payload_q[i], 1'b1, close && i == payload_q.size() - 1, seq, ts, pt, ok);
        else
          add_item(payload_q[i], 1'b0, close && i == payload_q.size() - 1, seq, ts,
                   7'($urandom), 1'($urandom));
      end
    payload_q.delete();
  endtask

  task automatic gen_single();
    int k, n, i;
    logic [7:0] hdr;
    k = $urandom_range(0, 9);
    hdr = 8'($urandom);
    if (k == 0) hdr[4:0] = TYPE_SPS;
    else if (k == 1) hdr[4:0] = TYPE_PPS;
    else if (hdr[4:0] == FUA_TYPE) hdr[4:0] = 5'd1;
    payload_q.insert(payload_q.size(), hdr);
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) payload_q.insert(payload_q.size(), 8'($urandom));
    cur_seq = cur_seq + 16'd1;
    add_packet(cur_seq, cur_ts, h264_pt_m, 1'b1, $urandom_range(0, 9) != 0, 0);
  endtask

  task automatic gen_fua_nal();
    int nfrag, nd, i, j;
    logic [4:0] nt;
    logic [1:0] nri;
    logic s, e, r, close;
    bit twice;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0] ind;
    nfrag = $urandom_range(2, 4);
    nt = 5'($urandom);
    nri = 2'($urandom);
    for (i = 0; i < nfrag; i++) begin
      s = (i == 0);
      e = (i == nfrag - 1);
      r = 1'b0;
      close = 1'b1;
      twice = 0;
      seq = cur_seq + 16'd1;
      ts = cur_ts;
      nd = $urandom_range(1, 4);
      case ($urandom_range(0, 24))
        0: r = 1'b1;
        1: seq = cur_seq + 16'd2;
        2: ts = cur_ts + 32'd1;
        3: twice = 1;
        4: close = 1'b0;
        5: nd = 0;
        6: nd = -1;
        7: seq = cur_seq;
        8: e = 1'b1;
        9: seq = cur_seq - 16'd1;
        default: ;
      endcase
      ind = 8'($urandom);
      ind[6:5] = nri;
      ind[4:0] = FUA_TYPE;
      payload_q.insert(payload_q.size(), ind);
      if (nd >= 0) payload_q.insert(payload_q.size(), {s, e, r, nt});
      for (j = 0; j < nd; j++) payload_q.insert(payload_q.size(), 8'($urandom));
      add_packet(seq, ts, h264_pt_m, 1'b1, close, twice);
      cur_seq = seq;
    end
  endtask

  task automatic gen_noise();
    int n, i;
    logic ok;
    logic [6:0] pt;
    noise_mode = 1;
    n = $urandom_range(1, 4);
    case ($urandom_range(0, 3))
      0: begin
        ok = 1'($urandom);
        pt = ok ? (h264_pt_m ^ 7'($urandom_range(1, 127))) : h264_pt_m;
        for (i = 0; i < n; i++) payload_q.insert(payload_q.size(), 8'($urandom));
        add_packet(cur_seq + 16'd1, cur_ts, pt, ok, 1'b1, 0);
      end
      1: for (i = 0; i < n; i++)
        add_item(8'($urandom), 1'b0, 1'($urandom), cur_seq, cur_ts, h264_pt_m, 1'b1);
      2: for (i = 0; i < n; i++)
        add_item(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom), 16'($urandom),
                 $urandom, 7'($urandom), 1'($urandom));
      default: begin
        payload_q.insert(payload_q.size(), {3'($urandom), FUA_TYPE});
        payload_q.insert(payload_q.size(), 8'($urandom));
        for (i = 0; i < n; i++) payload_q.insert(payload_q.size(), 8'($urandom));
        add_packet(cur_seq + 16'($urandom_range(0, 2)), cur_ts, h264_pt_m, 1'b1, 1'b1, 0);
      end
    endcase
    noise_mode = 0;
  endtask

  task automatic fill_random(input int n);
    int start, k;
    start = useful_count;
    while (useful_count - start < n) begin
      if ($urandom_range(0, 19) == 0) cur_ts = $urandom;
      else if ($urandom_range(0, 1) == 1) cur_ts = cur_ts + 32'($urandom_range(1, 3000));
      k = $urandom_range(0, 99);
      if (k < 45) gen_fua_nal();
      else if (k < 75) gen_single();
      else gen_noise();
    end
  endtask

  task automatic wait_idle();
    while (pkt_pending_q.size() != 0 || pkt_valid || nal_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sps with long start code, pps, unfinished single nal
    add_item(8'h67, 1'b1, 1'b0, 16'd1, 32'hFFFF_FFFF, 7'd96, 1'b1);
    add_item(8'hFF, 1'b0, 1'b1, 16'd1, 32'hFFFF_FFFF, 7'd96, 1'b1);
    add_item(8'h68, 1'b1, 1'b1, 16'd2, 32'hFFFF_FFFF, 7'd96, 1'b1);
    add_item(8'h41, 1'b1, 1'b0, 16'd3, 32'h0000_1000, 7'd96, 1'b1);
    add_item(8'h00, 1'b0, 1'b0, 16'd3, 32'h0000_1000, 7'd96, 1'b1);
    // fu-a start, middle, end
    add_item(8'h7C, 1'b1, 1'b0, 16'd10, 32'h0, 7'd96, 1'b1);
    add_item(8'h85, 1'b0, 1'b0, 16'd10, 32'h0, 7'd96, 1'b1);
    add_item(8'hAA, 1'b0, 1'b1, 16'd10, 32'h0, 7'd96, 1'b1);
    add_item(8'hFC, 1'b1, 1'b0, 16'd11, 32'h0, 7'd96, 1'b1);
    add_item(8'h05, 1'b0, 1'b0, 16'd11, 32'h0, 7'd96, 1'b1);
    add_item(8'h11, 1'b0, 1'b1, 16'd11, 32'h0, 7'd96, 1'b1);
    add_item(8'h7C, 1'b1, 1'b0, 16'd12, 32'h0, 7'd96, 1'b1);
    add_item(8'h45, 1'b0, 1'b0, 16'd12, 32'h0, 7'd96, 1'b1);
    add_item(8'h00, 1'b0, 1'b0, 16'd12, 32'h0, 7'd96, 1'b1);
    add_item(8'hFF, 1'b0, 1'b1, 16'd12, 32'h0, 7'd96, 1'b1);
    // rejected header, foreign payload type, byte outside a packet
    add_item(8'h65, 1'b1, 1'b1, 16'd13, 32'h0, 7'd96, 1'b0);
    add_item(8'h65, 1'b1, 1'b1, 16'd13, 32'h0, 7'd97, 1'b1);
    add_item(8'h33, 1'b0, 1'b0, 16'd13, 32'h0, 7'd96, 1'b1);
    // middle fragment with nothing open
    add_item(8'h5C, 1'b1, 1'b0, 16'd13, 32'h0, 7'd96, 1'b1);
    add_item(8'h05, 1'b0, 1'b0, 16'd13, 32'h0, 7'd96, 1'b1);
    add_item(8'h22, 1'b0, 1'b1, 16'd13, 32'h0, 7'd96, 1'b1);
    // single nal cutting into an open fragment
    add_item(8'h7C, 1'b1, 1'b0, 16'd20, 32'h0000_0200, 7'd96, 1'b1);
    add_item(8'h81, 1'b0, 1'b0, 16'd20, 32'h0000_0200, 7'd96, 1'b1);
    add_item(8'h01, 1'b0, 1'b1, 16'd20, 32'h0000_0200, 7'd96, 1'b1);
    add_item(8'h09, 1'b1, 1'b1, 16'd21, 32'h0000_0300, 7'd96, 1'b1);
    wait_idle();

    write_reg(REG_EMIT_START_CODE, 7'd0);
    write_reg(REG_H264_PAYLOAD_TYPE, 7'd0);
    cur_seq = 16'hFFF0;
    fill_random(80);
    wait_idle();

    write_reg(REG_EMIT_START_CODE, 7'd1);
    write_reg(REG_H264_PAYLOAD_TYPE, 7'd127);
    cur_seq = 16'($urandom);
    fill_random(80);
    wait_idle();

    write_reg(REG_H264_PAYLOAD_TYPE, H264_PAYLOAD_TYPE_RESET);
    fill_random(90);
    wait_idle();

    write_reg(REG_EMIT_START_CODE, 7'd0);
    write_reg(REG_H264_PAYLOAD_TYPE, 7'($urandom_range(1, 126)));
    cur_seq = 16'($urandom);
    fill_random(80);
    wait_idle();

    if (mismatch_count == 0) $display("tb_h264_rtp_depacketizer: done, clean");
    else $display("tb_h264_rtp_depacketizer: done, errors");
    $finish;
  end

endmodule
